[rtl/core/rbo_pkg.sv]
// Shared types, constants and the arctangent table for the range/bearing pipeline.
// Used by range_bearing_observation, rbo_iter and rbo_check; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rbo_pkg;

  // Iteration stages: one square-root bit and at most one CORDIC step per stage
  localparam int STEPS             = 32;
  localparam int CORDIC_STAGES_DEF = 16;
  // CORDIC datapath width: 33-bit offset scaled by 2^20 plus growth headroom
  localparam int CW                = 56;
  localparam int PRESHIFT          = 20;
  localparam logic [31:0] LIMIT_RESET = 32'd196608;
  localparam logic [31:0] HALF_TURN   = 32'h8000_0000;
  localparam logic [31:0] ROUND_HALF  = 32'h0000_8000;

  // atan(2^-i) in 2^32 units per turn
  localparam logic [31:0] ATAN_TAB [STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_heading;
    logic signed [31:0] mark_x;
    logic signed [31:0] mark_y;
    logic        [15:0] mark_id;
  } in_t;

  typedef struct packed {
    logic        [15:0] out_id;
    logic        [31:0] distance;
    logic signed [15:0] bearing;
    logic               seen;
  } out_t;

  // Per-item state carried through the iteration stages
  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic        [31:0]   cz;
    logic        [63:0]   rem;
    logic        [63:0]   root;
    logic                 sat;
    logic                 zero;
    logic        [15:0]   heading;
    logic        [15:0]   id;
  } iter_t;

endpackage

`default_nettype wire

[rtl/core/rbo_iter.sv]
// One iteration stage: a restoring square-root bit and, when ACTIVE, one CORDIC vectoring step.
// Depends on rbo_pkg for iter_t and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module rbo_iter #(
  parameter int IDX    = 0,
  parameter bit ACTIVE = 1'b1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          prev_valid,
  input  wire rbo_pkg::iter_t prev,
  output logic               valid,
  output rbo_pkg::iter_t     data
);

  localparam logic [63:0] SQ_BIT = 64'(1) << (62 - 2 * IDX);

  rbo_pkg::iter_t nxt;
  logic [63:0]    trial;

  // Square-root bit and, when ACTIVE, CORDIC rotation toward the x axis
  always_comb begin
    nxt   = prev;
    trial = prev.root + SQ_BIT;
    if (prev.rem >= trial) begin
      nxt.rem  = prev.rem - trial;
      nxt.root = (prev.root >> 1) + SQ_BIT;
    end else begin
      nxt.root = prev.root >> 1;
    end
    if (ACTIVE) begin
      if (prev.cy < 0) begin
        nxt.cx = prev.cx - (prev.cy >>> IDX);
        nxt.cy = prev.cy + (prev.cx >>> IDX);
        nxt.cz = prev.cz - rbo_pkg::ATAN_TAB[IDX];
      end else begin
        nxt.cx = prev.cx + (prev.cy >>> IDX);
        nxt.cy = prev.cy - (prev.cx >>> IDX);
        nxt.cz = prev.cz + rbo_pkg::ATAN_TAB[IDX];
      end
    end
  end

  // Advance on enable
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/range_bearing_observation.sv]
// Throughput one item per cycle while the output is not stalled.
// Pipeline: 5 setup registers (input, offset, magnitude, squares, sum), 32 iteration
// stages (one square-root bit each, CORDIC steps in the first CORDIC_STAGES) and
// 1 output stage; the input register loads at the transfer edge itself.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset (synchronous): pipeline empty, observe_limit back to 3.0 m.
`timescale 1ns / 1ps
`default_nettype none

module range_bearing_observation #(
  parameter int CORDIC_STAGES = rbo_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rbo_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rbo_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [31:0]   cfg_data
);

  logic        en;
  logic [31:0] observe_limit;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Hold the range limit
  always_ff @(posedge clk) begin
    if (rst) begin
      observe_limit <= rbo_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      observe_limit <= cfg_data;
    end
  end

  // Setup stage valid bits
  logic v0, v1, v2, v3, v4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  rbo_pkg::in_t       d0;
  logic signed [32:0] dx, dy;
  logic [15:0]        h1, id1;
  logic [31:0]        ax, ay;
  logic [63:0]        sx, sy;
  rbo_pkg::iter_t     p2, p3, p4;
  rbo_pkg::iter_t     p2_next, p4_next;
  logic signed [32:0] adx, ady;
  logic signed [rbo_pkg::CW-1:0] xs, ys;
  logic [64:0]        sum;

  // Offset magnitudes and CORDIC pre-rotation
  always_comb begin
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    xs  = rbo_pkg::CW'(dx) <<< rbo_pkg::PRESHIFT;
    ys  = rbo_pkg::CW'(dy) <<< rbo_pkg::PRESHIFT;
    p2_next         = '0;
    p2_next.heading = h1;
    p2_next.id      = id1;
    p2_next.zero    = (dx == 0) && (dy == 0);
    if (dx < 0) begin
      p2_next.cx = -xs;
      p2_next.cy = -ys;
      p2_next.cz = rbo_pkg::HALF_TURN;
    end else begin
      p2_next.cx = xs;
      p2_next.cy = ys;
      p2_next.cz = '0;
    end
  end

  // Sum of squares and overflow flag
  always_comb begin
    sum          = {1'b0, sx} + {1'b0, sy};
    p4_next      = p3;
    p4_next.sat  = sum[64];
    p4_next.rem  = sum[63:0];
    p4_next.root = '0;
  end

  // Advance the setup stages
  always_ff @(posedge clk) begin
    if (en) begin
      d0  <= in_data;
      dx  <= {d0.mark_x[31], d0.mark_x} - {d0.robot_x[31], d0.robot_x};
      dy  <= {d0.mark_y[31], d0.mark_y} - {d0.robot_y[31], d0.robot_y};
      h1  <= d0.robot_heading;
      id1 <= d0.mark_id;
      ax  <= adx[31:0];
      ay  <= ady[31:0];
      p2  <= p2_next;
      sx  <= ax * ax;
      sy  <= ay * ay;
      p3  <= p2;
      p4  <= p4_next;
    end
  end

  // Iteration stages
  logic           sv [rbo_pkg::STEPS+1];
  rbo_pkg::iter_t sd [rbo_pkg::STEPS+1];
  assign sv[0] = v4;
  assign sd[0] = p4;

  for (genvar i = 0; i < rbo_pkg::STEPS; i++) begin : g_step
    rbo_iter #(
      .IDX    (i),
      .ACTIVE (i < CORDIC_STAGES)
    ) u_iter (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (sv[i]),
      .prev       (sd[i]),
      .valid      (sv[i+1]),
      .data       (sd[i+1])
    );
  end

  // Output stage: saturate, round angle, compare against limit
  rbo_pkg::iter_t fin;
  logic [31:0]    range_sat, zr;
  logic [15:0]    ang16;
  assign fin       = sd[rbo_pkg::STEPS];
  assign range_sat = fin.sat ? '1 : fin.root[31:0];
  assign zr        = fin.cz + rbo_pkg::ROUND_HALF;
  assign ang16     = fin.zero ? '0 : zr[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[rbo_pkg::STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.out_id   <= fin.id;
      out_data.distance <= range_sat;
      out_data.bearing  <= $signed(ang16 - fin.heading);
      out_data.seen     <= (range_sat <= observe_limit);
    end
  end

endmodule

`default_nettype wire

[rtl/core/rbo_check.sv]
// Port-level checks for range_bearing_observation, attached by bind.
// Depends on rbo_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module rbo_check (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire rbo_pkg::out_t out_data
);

  // A stalled result stays offered
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // An empty output slot never blocks input
  a_ready : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Zero range is always within the limit
  a_zero_seen : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.distance == 32'd0 |-> out_data.seen)
    else $error("zero range not seen");

  // Reset leaves no result valid
  a_reset : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind range_bearing_observation rbo_check u_check (.*);

`default_nettype wire
